FILE: rtl/psuapc_pkg.sv
// Package for the power-supply auto controller: request kinds, register
// indexes, field widths, the configuration struct and the temperature check.
// Used by psuapc_csr and psu_auto_power_controller_top; depends on nothing.
package psuapc_pkg;

   localparam int unsigned TIME_BITS_DEFAULT       = 32;
   localparam int unsigned CHECK_PERIOD_MS_DEFAULT = 2500;

   localparam int unsigned MS_PER_S      = 1000;
   localparam int unsigned MS_MULT_BITS  = 10;
   localparam int unsigned SECS_BITS     = 16;
   localparam int unsigned LIMIT_BITS    = 10;
   localparam int unsigned TEMP_BITS     = 11;
   localparam int unsigned DELAY_BITS    = 32;
   localparam int unsigned KIND_BITS     = 3;
   localparam int unsigned CSR_IDX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS = 16;

   // Request item layout in tdata, lowest bit first.
   localparam int unsigned REQ_FIELD_BITS = 71;
   localparam int unsigned REQ_DATA_BITS  = 72;
   localparam int unsigned RSP_DATA_BITS  = 8;

   typedef enum logic [KIND_BITS-1:0] {
      REQ_TICK     = 3'd0,
      REQ_INIT     = 3'd1,
      REQ_ON       = 3'd2,
      REQ_OFF      = 3'd3,
      REQ_TIMER    = 3'd4,
      REQ_COOLDOWN = 3'd5,
      REQ_OFF_SOON = 3'd6,
      REQ_CANCEL   = 3'd7
   } req_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEFAULT_OFF   = 3'd0,
      CSR_ACTIVE_LEVEL  = 3'd1,
      CSR_TIMEOUT       = 3'd2,
      CSR_OFF_DELAY     = 3'd3,
      CSR_HOTEND_LIMIT  = 3'd4,
      CSR_CHAMBER_LIMIT = 3'd5,
      CSR_COOLER_LIMIT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                  default_off;
      logic                  active_level;
      logic                  timeout_en;
      logic                  off_delay_en;
      logic [LIMIT_BITS-1:0] hotend_limit;
      logic [LIMIT_BITS-1:0] chamber_limit;
      logic [LIMIT_BITS-1:0] cooler_limit;
   } cfg_type;

   // A zero limit disables the check for that sensor.
   function automatic logic is_hot(input logic signed [TEMP_BITS-1:0] temp,
                                   input logic [LIMIT_BITS-1:0] limit);
      logic signed [TEMP_BITS-1:0] lim_s;
      lim_s = $signed({1'b0, limit});
      return (limit != '0) && (temp >= lim_s);
   endfunction

endpackage

FILE: rtl/psu_auto_power_controller_top.sv
// Power-supply auto controller: input register, combinational state update and
// result register. A result is registered when its item advances out of the
// input register, which holds it while an untaken result waits for rsp_tready.
// One item is taken every cycle while results are drained; the state update is
// combinational, so the clock, stamp and deadline registers keep that pace.
// Synchronous active-high reset clears the millisecond clock, the supply state,
// all stamps and deadlines, the configuration registers and both handshake valid flags.
module psu_auto_power_controller_top
   import psuapc_pkg::*;
#(
   parameter int unsigned TIME_BITS       = TIME_BITS_DEFAULT,
   parameter int unsigned CHECK_PERIOD_MS = CHECK_PERIOD_MS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0: pause, steppers_enabled, job_active, fan_active,
   // heater_active, hotend_temp[10:0], chamber_temp[10:0], cooler_temp[10:0],
   // timer_ms[31:0], cooldown_enable, one zero pad bit.
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // Field: req_type.
   input  logic [KIND_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0: supply_pin, supply_on, turned_on, turned_off,
   // power_needed, cooling_needed, two zero pad bits.
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type              cfg;
   logic [TIME_BITS-1:0] timeout_ms;
   logic [TIME_BITS-1:0] off_delay_ms;

   psuapc_csr #(
      .TIME_BITS (TIME_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .timeout_ms   (timeout_ms),
      .off_delay_ms (off_delay_ms)
   );

   // Handshake stages.
   logic                      in_valid_ff;
   logic                      out_valid_ff;
   logic                      advance;
   logic [REQ_FIELD_BITS-1:0] in_data_ff;
   req_kind_type              in_kind_ff;
   logic [RSP_DATA_BITS-1:0]  out_data_ff;
   logic [RSP_DATA_BITS-1:0]  out_data_in;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_kind_ff <= REQ_TICK;
      end else if (req_tvalid && req_tready) begin
         in_kind_ff <= req_kind_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[REQ_FIELD_BITS-1:0];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Fields of the registered item.
   logic                        pause;
   logic [3:0]                  activity;
   logic signed [TEMP_BITS-1:0] hotend_temp;
   logic signed [TEMP_BITS-1:0] chamber_temp;
   logic signed [TEMP_BITS-1:0] cooler_temp;
   logic [DELAY_BITS-1:0]       timer_ms;
   logic                        cooldown_enable;

   assign pause           = in_data_ff[0];
   assign activity        = in_data_ff[4:1];
   assign hotend_temp     = $signed(in_data_ff[15:5]);
   assign chamber_temp    = $signed(in_data_ff[26:16]);
   assign cooler_temp     = $signed(in_data_ff[37:27]);
   assign timer_ms        = in_data_ff[69:38];
   assign cooldown_enable = in_data_ff[70];

   // Controller state.
   logic [TIME_BITS-1:0] now_ms_ff, now_ms_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic [TIME_BITS-1:0] next_check_ff, next_check_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic                 supply_ff, supply_in;
   logic                 pause_latch_ff, pause_latch_in;
   logic                 cooldown_ff, cooldown_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff      <= '0;
         stamp_ff       <= '0;
         next_check_ff  <= '0;
         deadline_ff    <= '0;
         supply_ff      <= 1'b0;
         pause_latch_ff <= 1'b0;
         cooldown_ff    <= 1'b0;
      end else if (advance) begin
         now_ms_ff      <= now_ms_in;
         stamp_ff       <= stamp_in;
         next_check_ff  <= next_check_in;
         deadline_ff    <= deadline_in;
         supply_ff      <= supply_in;
         pause_latch_ff <= pause_latch_in;
         cooldown_ff    <= cooldown_in;
      end
   end

   logic                 cooling;
   logic                 needed;
   logic [TIME_BITS-1:0] now_inc;
   logic [TIME_BITS-1:0] stamp_now;
   logic [TIME_BITS-1:0] stamp_inc;
   logic [TIME_BITS-1:0] stamp_tick;
   logic [TIME_BITS-1:0] idle_diff;
   logic [TIME_BITS-1:0] check_diff;
   logic [TIME_BITS-1:0] timer_diff;
   logic                 idle_due;
   logic                 check_due;
   logic                 timer_due;
   logic                 skip_check;
   logic                 hold;
   logic                 turned_on;
   logic                 turned_off;

   assign cooling = is_hot(hotend_temp, cfg.hotend_limit) ||
                    is_hot(chamber_temp, cfg.chamber_limit) ||
                    is_hot(cooler_temp, cfg.cooler_limit);
   assign needed  = (|activity) || cooling;

   // A stamp of zero means never on, so a stamp taken from the clock is never zero.
   assign now_inc    = now_ms_ff + TIME_BITS'(1);
   assign stamp_now  = (now_ms_ff == '0) ? TIME_BITS'(1) : now_ms_ff;
   assign stamp_inc  = (now_inc == '0) ? TIME_BITS'(1) : now_inc;
   assign stamp_tick = (cfg.timeout_en && (pause != pause_latch_ff)) ? stamp_inc : stamp_ff;
   assign skip_check = cfg.timeout_en && pause;

   // Wrap-safe compares: a time is reached when the difference is not negative.
   assign idle_diff  = now_inc - stamp_tick - timeout_ms;
   assign check_diff = now_inc - next_check_ff;
   assign timer_diff = now_inc - deadline_ff;
   assign idle_due   = !idle_diff[TIME_BITS-1];
   assign check_due  = !check_diff[TIME_BITS-1];
   assign timer_due  = !timer_diff[TIME_BITS-1];

   always_comb begin
      now_ms_in      = now_ms_ff;
      stamp_in       = stamp_ff;
      next_check_in  = next_check_ff;
      deadline_in    = deadline_ff;
      supply_in      = supply_ff;
      pause_latch_in = pause_latch_ff;
      cooldown_in    = cooldown_ff;
      turned_on      = 1'b0;
      turned_off     = 1'b0;
      hold           = 1'b0;

      unique case (in_kind_ff)
         REQ_TICK: begin
            now_ms_in = now_inc;
            stamp_in  = stamp_tick;
            if (cfg.timeout_en) begin
               pause_latch_in = pause;
            end
            if (!skip_check && check_due) begin
               next_check_in = now_inc + TIME_BITS'(CHECK_PERIOD_MS);
               if (needed) begin
                  stamp_in = stamp_inc;
                  if (!supply_ff) begin
                     supply_in   = 1'b1;
                     turned_on   = 1'b1;
                     deadline_in = '0;
                     cooldown_in = 1'b0;
                  end
               end else if ((stamp_tick == '0 || (cfg.timeout_en && idle_due)) &&
                            supply_ff) begin
                  supply_in   = 1'b0;
                  turned_off  = 1'b1;
                  deadline_in = '0;
                  cooldown_in = 1'b0;
               end
            end
            // Timed or cooldown power-off, after the periodic check.
            if (deadline_in != '0 || cooldown_in) begin
               hold = (cooldown_in && cooling) || (deadline_in != '0 && !timer_due);
               if (!hold && supply_in) begin
                  supply_in   = 1'b0;
                  turned_off  = 1'b1;
                  deadline_in = '0;
                  cooldown_in = 1'b0;
               end
            end
         end
         REQ_INIT: begin
            // Init always reports a switch, whatever the current supply state.
            deadline_in = '0;
            cooldown_in = 1'b0;
            if (cfg.default_off) begin
               supply_in  = 1'b0;
               turned_off = 1'b1;
            end else begin
               stamp_in  = stamp_now;
               supply_in = 1'b1;
               turned_on = 1'b1;
            end
         end
         REQ_ON: begin
            stamp_in = stamp_now;
            if (!supply_ff) begin
               supply_in   = 1'b1;
               turned_on   = 1'b1;
               deadline_in = '0;
               cooldown_in = 1'b0;
            end
         end
         REQ_OFF: begin
            if (supply_ff) begin
               supply_in   = 1'b0;
               turned_off  = 1'b1;
               deadline_in = '0;
               cooldown_in = 1'b0;
            end
         end
         REQ_TIMER: begin
            deadline_in = now_ms_ff + TIME_BITS'(timer_ms);
         end
         REQ_COOLDOWN: begin
            cooldown_in = cooldown_enable;
         end
         REQ_OFF_SOON: begin
            if (cfg.off_delay_en) begin
               stamp_in = now_ms_ff - timeout_ms + off_delay_ms;
            end
         end
         REQ_CANCEL: begin
            deadline_in = '0;
            cooldown_in = 1'b0;
         end
      endcase
   end

   assign out_data_in = {2'b00, cooling, needed, turned_off, turned_on, supply_in,
                         ~(supply_in ^ cfg.active_level)};

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("turned_on and turned_off set in the same item");

   a_flags_match_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3])) |-> (rsp_tdata[1] == rsp_tdata[2]))
      else $error("switch flag disagrees with supply state");

   a_tick_advances_clock: assert property (@(posedge clock) disable iff (reset)
      (advance && in_kind_ff == REQ_TICK) |=> (now_ms_ff == $past(now_ms_ff) + TIME_BITS'(1)))
      else $error("tick item did not advance the millisecond clock");

   a_off_cancels_auto: assert property (@(posedge clock) disable iff (reset)
      (advance && turned_off) |=> (deadline_ff == '0 && !cooldown_ff))
      else $error("power off left the auto-off armed");
`endif

endmodule

FILE: rtl/psuapc_csr.sv
// Configuration registers of the power-supply auto controller. The second
// counts are turned into milliseconds when written. Depends on psuapc_pkg.
module psuapc_csr
   import psuapc_pkg::*;
#(
   parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg,
   output logic [TIME_BITS-1:0]     timeout_ms,
   output logic [TIME_BITS-1:0]     off_delay_ms
);

   localparam int unsigned PROD_BITS = (TIME_BITS > SECS_BITS + MS_MULT_BITS) ?
                                       TIME_BITS : SECS_BITS + MS_MULT_BITS;

   cfg_type              cfg_ff;
   logic [TIME_BITS-1:0] timeout_ms_ff;
   logic [TIME_BITS-1:0] off_delay_ms_ff;
   logic [PROD_BITS-1:0] wdata_ms;

   assign wdata_ms = PROD_BITS'(csr_wdata) * PROD_BITS'(MS_PER_S);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= '0;
         timeout_ms_ff   <= '0;
         off_delay_ms_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEFAULT_OFF:   cfg_ff.default_off  <= csr_wdata[0];
            CSR_ACTIVE_LEVEL:  cfg_ff.active_level <= csr_wdata[0];
            CSR_TIMEOUT: begin
               cfg_ff.timeout_en <= (csr_wdata != '0);
               timeout_ms_ff     <= wdata_ms[TIME_BITS-1:0];
            end
            CSR_OFF_DELAY: begin
               cfg_ff.off_delay_en <= (csr_wdata != '0);
               off_delay_ms_ff     <= wdata_ms[TIME_BITS-1:0];
            end
            CSR_HOTEND_LIMIT:  cfg_ff.hotend_limit  <= csr_wdata[LIMIT_BITS-1:0];
            CSR_CHAMBER_LIMIT: cfg_ff.chamber_limit <= csr_wdata[LIMIT_BITS-1:0];
            CSR_COOLER_LIMIT:  cfg_ff.cooler_limit  <= csr_wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg          = cfg_ff;
   assign timeout_ms   = timeout_ms_ff;
   assign off_delay_ms = off_delay_ms_ff;

endmodule

FILE: tb/tb_psu_auto_power_controller_top.sv
// Self-checking testbench for the power-supply auto controller: a directed
// table followed by randomized request traffic, checked against a predictor.
// Depends on psuapc_pkg and psu_auto_power_controller_top only.
module tb_psu_auto_power_controller_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psuapc_pkg::*;

   localparam int TEMPS_ANY  = 0;
   localparam int TEMPS_HOT  = 1;
   localparam int TEMPS_COOL = 2;
   localparam int PLAN_LEN   = 25;
   localparam int PHASES     = 8;

   // Request fields as packed into req_tdata, pause in bit 0.
   typedef struct packed {
      logic                        cooldown_enable;
      logic [DELAY_BITS-1:0]       timer_ms;
      logic signed [TEMP_BITS-1:0] cooler_temp;
      logic signed [TEMP_BITS-1:0] chamber_temp;
      logic signed [TEMP_BITS-1:0] hotend_temp;
      logic                        heater_active;
      logic                        fan_active;
      logic                        job_active;
      logic                        steppers_enabled;
      logic                        pause;
   } req_fields_t;

   // Result fields as packed into rsp_tdata, supply_pin in bit 0.
   typedef struct packed {
      logic cooling_needed;
      logic power_needed;
      logic turned_off;
      logic turned_on;
      logic supply_on;
      logic supply_pin;
   } psu_status_t;

   typedef struct packed {
      req_kind_type                kind;
      logic                        pause;
      logic [3:0]                  activity;   // heater, fan, job, steppers
      logic signed [TEMP_BITS-1:0] hotend;
      logic signed [TEMP_BITS-1:0] chamber;
      logic signed [TEMP_BITS-1:0] cooler;
      logic [DELAY_BITS-1:0]       delay;
      logic                        cooldown;
      logic                        zero_sum;   // delay chosen so the deadline sums to zero
      logic                        typed;
      psu_status_t                 want;       // {cool, need, off, on, supply, pin}
   } plan_row_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [KIND_BITS-1:0]     req_tuser = REQ_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Register copies kept by the predictor.
   logic                  cfg_default_off = 1'b0;
   logic                  cfg_level = 1'b0;
   logic [SECS_BITS-1:0]  cfg_timeout = '0;
   logic [SECS_BITS-1:0]  cfg_off_delay = '0;
   logic [LIMIT_BITS-1:0] lim_hotend = '0;
   logic [LIMIT_BITS-1:0] lim_chamber = '0;
   logic [LIMIT_BITS-1:0] lim_cooler = '0;

   // Controller state kept by the predictor.
   logic [31:0] ms_clock = '0;
   logic [31:0] on_stamp = '0;
   logic [31:0] check_at = '0;
   logic [31:0] off_at = '0;
   logic        psu_on = 1'b0;
   logic        paused = 1'b0;
   logic        cool_arm = 1'b0;
   logic        went_on, went_off;

   psu_status_t status_q[$];
   logic        use_typed = 1'b0;
   psu_status_t typed_status = '0;
   logic        steady = 1'b0;
   logic [3:0]  tick_flags = '0;
   logic        tick_pause = 1'b0;
   int          sent = 0;
   int          mismatches = 0;
   int          n_ticks = 0, n_cmds = 0, n_results = 0;
   int          n_on = 0, n_off = 0, n_cool = 0;

   plan_row_t plan [PLAN_LEN] = '{
      '{REQ_ON,       1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b000111},
      '{REQ_TICK,     1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b000011},
      '{REQ_ON,       1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b000011},
      '{REQ_OFF,      1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b001000},
      '{REQ_OFF,      1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b000000},
      '{REQ_INIT,     1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b000111},
      '{REQ_CANCEL,   1'b0, 4'h0, 1023,    0,    0, 32'h0,         1'b0, 1'b0, 1'b1, 6'b110011},
      '{REQ_CANCEL,   1'b0, 4'h1, -128,  200, 1023, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_CANCEL,   1'b0, 4'h2, 1022,  199, 1023, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TICK,     1'b0, 4'h4,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_CANCEL,   1'b0, 4'h8,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TIMER,    1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b1, 1'b0, 6'b0},
      '{REQ_TICK,     1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TIMER,    1'b0, 4'h0,    0,    0,    0, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TICK,     1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TIMER,    1'b0, 4'h0,    0,    0,    0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TICK,     1'b0, 4'h8,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_ON,       1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_COOLDOWN, 1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b1, 1'b0, 1'b0, 6'b0},
      '{REQ_TICK,     1'b0, 4'h0, 1023,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_TICK,     1'b0, 4'h0,    0,   -1,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_OFF_SOON, 1'b1, 4'hF,    0,    0,    0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'b0},
      '{REQ_TICK,     1'b1, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_COOLDOWN, 1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0},
      '{REQ_INIT,     1'b0, 4'h0,    0,    0,    0, 32'h0,         1'b0, 1'b0, 1'b0, 6'b0}
   };

   psu_auto_power_controller_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Times are compared by the sign of their 32-bit difference.
   function automatic logic reached_at(input logic [31:0] now_t, input logic [31:0] mark);
      logic [31:0] gap;
      gap = now_t - mark;
      return !gap[31];
   endfunction

   function automatic logic over_limit(input logic signed [TEMP_BITS-1:0] t,
                                       input logic [LIMIT_BITS-1:0] lim);
      return (lim != 0) && (int'(t) >= int'(lim));
   endfunction

   // A stamp of zero means never on, so a power-on at time zero stamps one.
   function automatic logic [31:0] stamp_value();
      return (ms_clock != 0) ? ms_clock : 32'd1;
   endfunction

   function automatic void switch_on();
      on_stamp = stamp_value();
      if (!psu_on) begin
         off_at   = '0;
         cool_arm = 1'b0;
         psu_on   = 1'b1;
         went_on  = 1'b1;
      end
   endfunction

   function automatic void switch_off();
      if (psu_on) begin
         psu_on   = 1'b0;
         went_off = 1'b1;
         off_at   = '0;
         cool_arm = 1'b0;
      end
   endfunction

   function automatic void advance_controller(input req_kind_type kind, input req_fields_t f,
                                              output psu_status_t st);
      logic        cool, need, skip, hold_off;
      logic [31:0] idle_ms, grace_ms;
      cool = over_limit(f.hotend_temp, lim_hotend) | over_limit(f.chamber_temp, lim_chamber) |
             over_limit(f.cooler_temp, lim_cooler);
      need = f.steppers_enabled | f.job_active | f.fan_active | f.heater_active | cool;
      idle_ms  = 32'(cfg_timeout) * 32'd1000;
      grace_ms = 32'(cfg_off_delay) * 32'd1000;
      went_on  = 1'b0;
      went_off = 1'b0;
      case (kind)
         REQ_TICK: begin
            ms_clock = ms_clock + 32'd1;
            skip = 1'b0;
            // Pause handling only exists while an idle timeout is set.
            if (cfg_timeout != 0) begin
               if (f.pause != paused) begin
                  on_stamp = stamp_value();
                  paused   = f.pause;
               end
               skip = f.pause;
            end
            if (!skip && reached_at(ms_clock, check_at)) begin
               check_at = ms_clock + CHECK_PERIOD_MS_DEFAULT;
               if (need)
                  switch_on();
               else if (on_stamp == 0 ||
                        (cfg_timeout != 0 && reached_at(ms_clock, on_stamp + idle_ms)))
                  switch_off();
            end
            if (off_at != 0 || cool_arm) begin
               hold_off = (cool_arm && cool) || (off_at != 0 && !reached_at(ms_clock, off_at));
               if (!hold_off)
                  switch_off();
            end
         end
         REQ_INIT: begin
            // Init forces the opposite state first, so it always reports a switch.
            psu_on = cfg_default_off;
            if (cfg_default_off)
               switch_off();
            else
               switch_on();
         end
         REQ_ON:       switch_on();
         REQ_OFF:      switch_off();
         REQ_TIMER:    off_at = ms_clock + f.timer_ms;
         REQ_COOLDOWN: cool_arm = f.cooldown_enable;
         REQ_OFF_SOON: begin
            if (cfg_off_delay != 0)
               on_stamp = ms_clock - idle_ms + grace_ms;
         end
         default: begin
            off_at   = '0;
            cool_arm = 1'b0;
         end
      endcase
      st.supply_pin     = psu_on ? cfg_level : ~cfg_level;
      st.supply_on      = psu_on;
      st.turned_on      = went_on;
      st.turned_off     = went_off;
      st.power_needed   = need;
      st.cooling_needed = cool;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic want_b, input logic got_b);
      if (got_b !== want_b) begin
         mismatches++;
         $error("%s: expected %b, got %b", name, want_b, got_b);
      end
   endfunction

   always @(posedge clock) begin : status_check
      psu_status_t want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_controller(req_kind_type'(req_tuser),
                               req_fields_t'(req_tdata[REQ_FIELD_BITS-1:0]), want);
            if (use_typed)
               want = typed_status;
            status_q.push_back(want);
            if (req_tuser == REQ_TICK)
               n_ticks++;
            else
               n_cmds++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = psu_status_t'(rsp_tdata[$bits(psu_status_t)-1:0]);
            n_results++;
            n_on   += got.turned_on;
            n_off  += got.turned_off;
            n_cool += got.cooling_needed;
            if (status_q.size() == 0) begin
               mismatches++;
               $error("result %b arrived with no item outstanding", got);
            end else begin
               want = status_q.pop_front();
               check_field("supply_pin", want.supply_pin, got.supply_pin);
               check_field("supply_on", want.supply_on, got.supply_on);
               check_field("turned_on", want.turned_on, got.turned_on);
               check_field("turned_off", want.turned_off, got.turned_off);
               check_field("power_needed", want.power_needed, got.power_needed);
               check_field("cooling_needed", want.cooling_needed, got.cooling_needed);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Result side: ready runs mixed with stall bursts, or ready alone while steady is set.
   initial begin : sink_pacing
      int n;
      forever begin
         if (steady || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 12);
         end else begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 8);
         end
         repeat (n) @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_request(input req_kind_type kind, input req_fields_t f,
                                input logic typed, input psu_status_t want);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser    <= kind;
      req_tdata    <= {1'b0, f};
      use_typed    <= typed;
      typed_status <= want;
      sent++;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DEFAULT_OFF:   cfg_default_off = val[0];
         CSR_ACTIVE_LEVEL:  cfg_level = val[0];
         CSR_TIMEOUT:       cfg_timeout = val;
         CSR_OFF_DELAY:     cfg_off_delay = val;
         CSR_HOTEND_LIMIT:  lim_hotend = val[LIMIT_BITS-1:0];
         CSR_CHAMBER_LIMIT: lim_chamber = val[LIMIT_BITS-1:0];
         CSR_COOLER_LIMIT:  lim_cooler = val[LIMIT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_settings(input logic doff, input logic lvl,
                                   input logic [SECS_BITS-1:0] tmo, input logic [SECS_BITS-1:0] dly,
                                   input logic [LIMIT_BITS-1:0] h, input logic [LIMIT_BITS-1:0] c,
                                   input logic [LIMIT_BITS-1:0] k);
      write_reg(CSR_DEFAULT_OFF, 16'(doff));
      write_reg(CSR_ACTIVE_LEVEL, 16'(lvl));
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_OFF_DELAY, dly);
      write_reg(CSR_HOTEND_LIMIT, 16'(h));
      write_reg(CSR_CHAMBER_LIMIT, 16'(c));
      write_reg(CSR_COOLER_LIMIT, 16'(k));
      csr_we <= 1'b0;
   endtask

   function automatic logic [SECS_BITS-1:0] pick_seconds();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [LIMIT_BITS-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 10'd1;
         2:       return 10'd1023;
         default: return 10'($urandom_range(30, 300));
      endcase
   endfunction

   // Mostly room temperature, with the range ends and the limit edges mixed in.
   function automatic logic signed [TEMP_BITS-1:0] pick_temp(input logic [LIMIT_BITS-1:0] lim);
      int v;
      case ($urandom_range(0, 9))
         0:       v = -128;
         1:       v = 1023;
         2:       v = int'(lim) - 1;
         3:       v = int'(lim);
         4:       v = int'($urandom_range(0, 1151)) - 128;
         default: v = $urandom_range(15, 60);
      endcase
      return v[TEMP_BITS-1:0];
   endfunction

   function automatic logic [DELAY_BITS-1:0] pick_delay();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom;
         3:       return 32'h8000_0000 - 32'($urandom_range(0, 2)) + 32'($urandom_range(0, 2));
         default: return 32'($urandom_range(0, 60));
      endcase
   endfunction

   function automatic req_fields_t random_fields();
      req_fields_t f;
      f.pause = 1'($urandom);
      {f.heater_active, f.fan_active, f.job_active, f.steppers_enabled} =
         ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'h0;
      f.hotend_temp     = pick_temp(lim_hotend);
      f.chamber_temp    = pick_temp(lim_chamber);
      f.cooler_temp     = pick_temp(lim_cooler);
      f.timer_ms        = pick_delay();
      f.cooldown_enable = 1'($urandom);
      return f;
   endfunction

   task automatic run_ticks(input int n, input int heat);
      req_fields_t f;
      repeat (n) begin
         f = random_fields();
         f.pause = tick_pause;
         {f.heater_active, f.fan_active, f.job_active, f.steppers_enabled} = tick_flags;
         if (heat == TEMPS_HOT) begin
            f.hotend_temp  = 11'sd1023;
            f.chamber_temp = 11'sd1023;
            f.cooler_temp  = 11'sd1023;
         end else if (heat == TEMPS_COOL) begin
            f.hotend_temp  = 11'(-int'($urandom_range(0, 128)));
            f.chamber_temp = 11'(-int'($urandom_range(0, 128)));
            f.cooler_temp  = 11'(-int'($urandom_range(0, 128)));
         end
         offer_request(REQ_TICK, f, 1'b0, '0);
         if ($urandom_range(0, 39) == 0)
            tick_pause = ~tick_pause;
      end
   endtask

   // Well-formed request sequences with random content, plus stray commands.
   task automatic mixed_traffic(input int n_items, input logic calm);
      req_fields_t f;
      int          stop_at, d;
      req_kind_type k;
      stop_at = sent + n_items;
      while (sent < stop_at) begin
         steady = calm || ($urandom_range(0, 4) == 0);
         f = random_fields();
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               tick_flags = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h0;
               if ($urandom_range(0, 3) == 0)
                  tick_pause = 1'($urandom);
               run_ticks($urandom_range(1, 30), TEMPS_ANY);
            end
            3: begin
               offer_request(REQ_ON, f, 1'b0, '0);
               d = $urandom_range(0, 40);
               f.timer_ms = 32'(d);
               offer_request(REQ_TIMER, f, 1'b0, '0);
               run_ticks(d + 2, TEMPS_ANY);
            end
            4: begin
               offer_request(REQ_ON, f, 1'b0, '0);
               f.cooldown_enable = 1'b1;
               offer_request(REQ_COOLDOWN, f, 1'b0, '0);
               run_ticks($urandom_range(1, 10), TEMPS_HOT);
               run_ticks($urandom_range(1, 3), TEMPS_COOL);
            end
            5: begin
               offer_request(REQ_OFF_SOON, f, 1'b0, '0);
               run_ticks($urandom_range(1, 20), TEMPS_ANY);
            end
            6, 7: begin
               k = req_kind_type'($urandom_range(0, 7));
               offer_request(k, f, 1'b0, '0);
            end
            8: begin
               case ($urandom_range(0, 3))
                  0:       k = REQ_INIT;
                  1:       k = REQ_ON;
                  2:       k = REQ_OFF;
                  default: k = REQ_CANCEL;
               endcase
               offer_request(k, f, 1'b0, '0);
            end
            default: wait_drained();
         endcase
      end
   endtask

   initial begin : main_flow
      req_fields_t f;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      program_settings(1'b0, 1'b1, 16'd0, 16'd0, 10'd1023, 10'd200, 10'd0);

      for (int i = 0; i < PLAN_LEN; i++) begin
         f = '0;
         f.pause = plan[i].pause;
         {f.heater_active, f.fan_active, f.job_active, f.steppers_enabled} = plan[i].activity;
         f.hotend_temp     = plan[i].hotend;
         f.chamber_temp    = plan[i].chamber;
         f.cooler_temp     = plan[i].cooler;
         f.timer_ms        = plan[i].zero_sum ? -ms_clock : plan[i].delay;
         f.cooldown_enable = plan[i].cooldown;
         offer_request(plan[i].kind, f, plan[i].typed, plan[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0:       program_settings(1'b1, 1'b0, 16'd1, 16'd1, 10'd1, 10'd1023, 10'd0);
            1:       program_settings(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd0, 10'd1);
            2:       program_settings(1'b1, 1'b1, 16'd2, 16'd0, 10'd0, 10'd0, 10'd0);
            3:       program_settings(1'b0, 1'b0, 16'd0, 16'd3, 10'd60, 10'd45, 10'd30);
            default: program_settings(1'($urandom), 1'($urandom), pick_seconds(), pick_seconds(),
                                      pick_limit(), pick_limit(), pick_limit());
         endcase
         mixed_traffic(100, p >= PHASES - 2);
      end

      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Ran %0d ticks and %0d commands over %0d register settings; %0d results seen.",
               n_ticks, n_cmds, PHASES + 1, n_results);
      $display("Supply went on %0d times and off %0d times; cooling was needed on %0d results.",
               n_on, n_off, n_cool);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #(40_000_000);
      $error("run did not complete, %0d results still outstanding", status_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: psu_auto_power_controller_top.f
rtl/psuapc_pkg.sv
rtl/psuapc_csr.sv
rtl/psu_auto_power_controller_top.sv
tb/tb_psu_auto_power_controller_top.sv
